// ===== hw/rtl/ues_pkg.sv =====
// shared constants for the url endpoint splitter
package ues_pkg;

   localparam int CHAR_W   = 8;
   localparam int FIELD_W  = 13;
   localparam int STATUS_W = 3;
   localparam int DPORT_W  = 9;

   localparam logic [STATUS_W-1:0] STATUS_OK             = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ABSOLUTE   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN_SCHEME = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_HOST        = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG       = 3'd4;

   localparam logic SCHEME_HTTP  = 1'b0;
   localparam logic SCHEME_HTTPS = 1'b1;

   localparam logic [DPORT_W-1:0] PORT_HTTP  = 9'd80;
   localparam logic [DPORT_W-1:0] PORT_HTTPS = 9'd443;

   localparam int SCHEME_LEN = 5;
   localparam logic [CHAR_W-1:0] SCHEME_TEXT [SCHEME_LEN] = '{"h", "t", "t", "p", "s"};

   localparam logic [CHAR_W-1:0] CHAR_SLASH   = "/";
   localparam logic [CHAR_W-1:0] CHAR_COLON   = ":";
   localparam logic [CHAR_W-1:0] CHAR_OPEN    = "[";
   localparam logic [CHAR_W-1:0] CHAR_CLOSE   = "]";
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = "A";
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = "Z";
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

endpackage

// ===== hw/rtl/url_endpoint_splitter.sv =====
// url endpoint splitter: streaming parse of an absolute http/https url
//
// the request channel carries one url byte per transfer, req_last marking
// the final byte. each byte updates a small set of scan registers (separator
// search, scheme prefix match, bracket, colon and slash positions) in the
// cycle it is taken. on the last byte the result is formed from the updated
// scan state and loaded into the response register, so rsp_valid rises in the
// cycle after the last byte's transfer; the scan state then clears for the
// next url.
// throughput is one byte per cycle while req_ready is high, each byte needing
// one update of the scan registers. a response waiting in the output register
// does not block input while rsp_ready is high; with rsp_ready low and a
// response pending, req_ready drops until that response is taken.
// bytes past MAX_URL_LENGTH are neither counted nor examined; the url then
// reports too long with url_length equal to MAX_URL_LENGTH.
// reset (synchronous) clears the scan state and drops rsp_valid.
module url_endpoint_splitter #(
   parameter int MAX_URL_LENGTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ues_pkg::CHAR_W-1:0]    req_char_in,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ues_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_scheme_kind,
   output logic [ues_pkg::FIELD_W-1:0]   rsp_host_start,
   output logic [ues_pkg::FIELD_W-1:0]   rsp_host_length,
   output logic                          rsp_port_given,
   output logic [ues_pkg::FIELD_W-1:0]   rsp_port_start,
   output logic [ues_pkg::FIELD_W-1:0]   rsp_port_length,
   output logic [ues_pkg::DPORT_W-1:0]   rsp_default_port,
   output logic                          rsp_target_given,
   output logic [ues_pkg::FIELD_W-1:0]   rsp_target_start,
   output logic [ues_pkg::FIELD_W-1:0]   rsp_url_length
);
   import ues_pkg::*;

   // position counter must also hold the overflow mark MAX_URL_LENGTH + 1
   localparam int POS_W = $clog2(MAX_URL_LENGTH + 2);
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_URL_LENGTH);

   typedef struct packed {
      logic [POS_W-1:0]      byte_pos;
      logic [1:0]            sep_match;
      logic                  sep_found;
      logic [POS_W-1:0]      sep_pos;
      logic [SCHEME_LEN-1:0] prefix_ok;
      logic                  bracketed;
      logic                  close_found;
      logic [POS_W-1:0]      close_pos;
      logic                  colon_any_found;
      logic [POS_W-1:0]      colon_any_pos;
      logic                  colon_close_found;
      logic [POS_W-1:0]      colon_close_pos;
      logic                  slash_found;
      logic [POS_W-1:0]      slash_pos;
   } scan_type;

   localparam scan_type SCAN_RESET = '{
      byte_pos: '0, sep_match: '0, sep_found: 1'b0, sep_pos: '0,
      prefix_ok: '1, bracketed: 1'b0, close_found: 1'b0, close_pos: '0,
      colon_any_found: 1'b0, colon_any_pos: '0, colon_close_found: 1'b0,
      colon_close_pos: '0, slash_found: 1'b0, slash_pos: '0};

   scan_type scan_ff, scan_in;

   logic                req_xfer;
   logic [CHAR_W-1:0]   lower_char;
   logic [POS_W-1:0]    rs_cur;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                kind_ff, kind_in;
   logic [FIELD_W-1:0]  host_start_ff, host_start_in;
   logic [FIELD_W-1:0]  host_length_ff, host_length_in;
   logic                port_given_ff, port_given_in;
   logic [FIELD_W-1:0]  port_start_ff, port_start_in;
   logic [FIELD_W-1:0]  port_length_ff, port_length_in;
   logic [DPORT_W-1:0]  default_port_ff, default_port_in;
   logic                target_given_ff, target_given_in;
   logic [FIELD_W-1:0]  target_start_ff, target_start_in;
   logic [FIELD_W-1:0]  url_length_ff, url_length_in;

   // result side, formed from the scan state after the last byte
   logic                too_long;
   logic [POS_W-1:0]    len;
   logic [POS_W-1:0]    rs_new;
   logic [POS_W-1:0]    auth_end;
   logic                closed;
   logic                port;
   logic [POS_W-1:0]    mark;
   logic [POS_W-1:0]    host_start_w;
   logic [POS_W-1:0]    host_len_w;
   logic [POS_W-1:0]    port_start_w;
   logic [POS_W-1:0]    port_len_w;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // per-byte scan update
   always_comb begin
      scan_in    = scan_ff;
      rs_cur     = scan_ff.sep_pos + POS_W'(3);
      lower_char = (req_char_in inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) ?
                   req_char_in + CASE_OFFSET : req_char_in;
      if (scan_ff.byte_pos < MAX_POS) begin
         if (scan_ff.byte_pos < POS_W'(SCHEME_LEN) &&
             lower_char != SCHEME_TEXT[scan_ff.byte_pos[2:0]]) begin
            scan_in.prefix_ok[scan_ff.byte_pos[2:0]] = 1'b0;
         end
         if (scan_ff.sep_found) begin
            if (scan_ff.byte_pos >= rs_cur && !scan_ff.slash_found) begin
               if (scan_ff.byte_pos == rs_cur && req_char_in == CHAR_OPEN) begin
                  scan_in.bracketed = 1'b1;
               end
               if (req_char_in == CHAR_SLASH) begin
                  scan_in.slash_found = 1'b1;
                  scan_in.slash_pos   = scan_ff.byte_pos;
               end else if (req_char_in == CHAR_CLOSE) begin
                  if (scan_ff.bracketed && !scan_ff.close_found) begin
                     scan_in.close_found = 1'b1;
                     scan_in.close_pos   = scan_ff.byte_pos;
                  end
               end else if (req_char_in == CHAR_COLON) begin
                  if (!scan_ff.colon_any_found) begin
                     scan_in.colon_any_found = 1'b1;
                     scan_in.colon_any_pos   = scan_ff.byte_pos;
                  end
                  if (scan_ff.close_found && !scan_ff.colon_close_found) begin
                     scan_in.colon_close_found = 1'b1;
                     scan_in.colon_close_pos   = scan_ff.byte_pos;
                  end
               end
            end
         end else begin
            // looking for "://"
            if (scan_ff.sep_match == 2'd2 && req_char_in == CHAR_SLASH) begin
               scan_in.sep_found = 1'b1;
               scan_in.sep_pos   = scan_ff.byte_pos - POS_W'(2);
               scan_in.sep_match = 2'd0;
            end else if (req_char_in == CHAR_COLON) begin
               scan_in.sep_match = 2'd1;
            end else if (scan_ff.sep_match == 2'd1 && req_char_in == CHAR_SLASH) begin
               scan_in.sep_match = 2'd2;
            end else begin
               scan_in.sep_match = 2'd0;
            end
         end
         scan_in.byte_pos = scan_ff.byte_pos + POS_W'(1);
      end else begin
         scan_in.byte_pos = MAX_POS + POS_W'(1);
      end
   end

   // result from the updated scan state
   always_comb begin
      too_long = scan_in.byte_pos > MAX_POS;
      len      = too_long ? MAX_POS : scan_in.byte_pos;
      rs_new   = scan_in.sep_pos + POS_W'(3);
      auth_end = scan_in.slash_found ? scan_in.slash_pos : len;
      if (auth_end < rs_new) begin
         auth_end = rs_new;
      end
      // an unclosed bracket is treated as part of a plain host
      closed = scan_in.bracketed && scan_in.close_found;
      port   = closed ? scan_in.colon_close_found : scan_in.colon_any_found;
      mark   = closed ? scan_in.colon_close_pos : scan_in.colon_any_pos;
      if (closed) begin
         host_start_w = rs_new + POS_W'(1);
         host_len_w   = scan_in.close_pos - rs_new - POS_W'(1);
      end else begin
         host_start_w = rs_new;
         host_len_w   = (port ? mark : auth_end) - rs_new;
      end
      port_start_w = mark + POS_W'(1);
      port_len_w   = auth_end - port_start_w;

      status_in       = STATUS_OK;
      kind_in         = SCHEME_HTTP;
      host_start_in   = '0;
      host_length_in  = '0;
      port_given_in   = 1'b0;
      port_start_in   = '0;
      port_length_in  = '0;
      default_port_in = '0;
      target_given_in = 1'b0;
      target_start_in = '0;
      url_length_in   = FIELD_W'(len);

      if (too_long) begin
         status_in = STATUS_TOO_LONG;
      end else if (!scan_in.sep_found) begin
         status_in = STATUS_NOT_ABSOLUTE;
      end else if (scan_in.sep_pos == POS_W'(4) && (&scan_in.prefix_ok[3:0])) begin
         kind_in = SCHEME_HTTP;
      end else if (scan_in.sep_pos == POS_W'(5) && (&scan_in.prefix_ok)) begin
         kind_in = SCHEME_HTTPS;
      end else begin
         status_in = STATUS_UNKNOWN_SCHEME;
      end

      if (status_in == STATUS_OK) begin
         if (host_len_w == '0) begin
            status_in = STATUS_NO_HOST;
            kind_in   = SCHEME_HTTP;
         end else begin
            host_start_in   = FIELD_W'(host_start_w);
            host_length_in  = FIELD_W'(host_len_w);
            default_port_in = kind_in ? PORT_HTTPS : PORT_HTTP;
            if (port) begin
               port_given_in  = 1'b1;
               port_start_in  = FIELD_W'(port_start_w);
               port_length_in = FIELD_W'(port_len_w);
            end
            if (scan_in.slash_found) begin
               target_given_in = 1'b1;
               target_start_in = FIELD_W'(scan_in.slash_pos);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer && req_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= SCAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            scan_ff <= req_last ? SCAN_RESET : scan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && req_last) begin
         status_ff       <= status_in;
         kind_ff         <= kind_in;
         host_start_ff   <= host_start_in;
         host_length_ff  <= host_length_in;
         port_given_ff   <= port_given_in;
         port_start_ff   <= port_start_in;
         port_length_ff  <= port_length_in;
         default_port_ff <= default_port_in;
         target_given_ff <= target_given_in;
         target_start_ff <= target_start_in;
         url_length_ff   <= url_length_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_scheme_kind  = kind_ff;
   assign rsp_host_start   = host_start_ff;
   assign rsp_host_length  = host_length_ff;
   assign rsp_port_given   = port_given_ff;
   assign rsp_port_start   = port_start_ff;
   assign rsp_port_length  = port_length_ff;
   assign rsp_default_port = default_port_ff;
   assign rsp_target_given = target_given_ff;
   assign rsp_target_start = target_start_ff;
   assign rsp_url_length   = url_length_ff;

endmodule
